/* rtl/core/bright_spot_cursor_selector_assert.svh */
// ----------------------------------------------------------------------------
// bright spot cursor selector assertion macros
// concurrent check wrappers for the rtl that carries assertions
// ----------------------------------------------------------------------------
`ifndef BRIGHT_SPOT_CURSOR_SELECTOR_ASSERT_SVH
`define BRIGHT_SPOT_CURSOR_SELECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bscs assertion failed");

// next-cycle implication, disabled during reset
`define BSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bscs assertion failed");

`endif

/* rtl/core/bscs_pkg.sv */
// ----------------------------------------------------------------------------
// bscs_pkg
// types and constants of the bright spot cursor selector
// ----------------------------------------------------------------------------
package bscs_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned AreaW  = 16;
  localparam int unsigned ScoreW = 24;
  localparam int unsigned DistW  = CoordW + 1;
  localparam int unsigned SqW    = 2 * CoordW;

  // circularity ratio: (200 * area * 65536) / (pi_q16 * r * r)
  localparam int unsigned PiW    = 18;
  localparam int unsigned NumW   = 40;
  localparam int unsigned DenW   = SqW + PiW;
  // quotient stays below 2^23 because r >= 1 and area < 2^16
  localparam int unsigned QuoW   = 23;
  localparam int unsigned StepW  = 5;

  localparam logic [PiW-1:0]         PiQ16      = 18'd205887;
  localparam logic [7:0]             CircMult   = 8'd200;
  localparam logic signed [ScoreW:0] CircBase   = 25'sd100;
  localparam logic signed [ScoreW-1:0] ScoreBound = 24'sd30000;

  typedef struct packed {
    logic              spot_valid;
    logic [CoordW-1:0] spot_x;
    logic [CoordW-1:0] spot_y;
    logic [CoordW-1:0] spot_radius;
    logic [AreaW-1:0]  spot_area;
    logic [CoordW-1:0] prev_x;
    logic [CoordW-1:0] prev_y;
    logic [CoordW-1:0] prev_radius;
    logic              frame_last;
  } bscs_item_t;

  typedef struct packed {
    logic [CoordW-1:0] best_x;
    logic [CoordW-1:0] best_y;
    logic [CoordW-1:0] best_radius;
    logic [AreaW-1:0]  best_area;
  } bscs_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bscs_div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_LAUNCH,
    ST_DIV,
    ST_SCORE,
    ST_OUT
  } bscs_state_e;

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/core/bright_spot_cursor_selector.sv */
// a blob word passes prep, scale, launch, 23 divider steps and score from acceptance
// to its score update; words are taken only while idle, so the next word waits until
// the current blob word is scored, mostly on the 23-step serial circularity divider
// a frame result sits in the output register until taken, then a new word is taken
// reset: asynchronous, clears target radius, best score to 30000 and held blob
// ----------------------------------------------------------------------------
// bright_spot_cursor_selector
// picks the lowest-score blob of a frame as the cursor and emits it at frame end
// ----------------------------------------------------------------------------
`include "bright_spot_cursor_selector_assert.svh"

module bright_spot_cursor_selector
  import bscs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: target radius
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CoordW-1:0] cfg_data_i,
  // blob words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bscs_item_t        in_data_i,
  // frame results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bscs_res_t         out_data_o
);

  bscs_state_e state_q, state_d;

  // captured word and config
  bscs_item_t        item_q;
  logic [CoordW-1:0] target_q;

  // score operands, filled over the prep and scale cycles
  logic [SqW-1:0]    rr_q;
  logic [NumW-1:0]   num_q;
  logic [DenW-1:0]   den_q;
  logic [CoordW-1:0] rad_q;
  logic [DistW-1:0]  dist_q;
  logic [DistW-1:0]  dist_d;

  // frame state
  logic signed [ScoreW-1:0] best_score_q, best_score_d;
  bscs_res_t                held_q, held_d, held_nx;
  bscs_res_t                out_q, out_d;

  // divider hookup
  logic            div_start;
  bscs_div_sts_t   div_sts;
  logic [QuoW-1:0] quo;

  logic                   in_fire;
  logic                   scored;
  logic signed [ScoreW:0] score;
  logic                   take;
  logic                   emit;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  // only blobs with a nonzero radius enter the scoring path
  assign scored      = in_data_i.spot_valid && (in_data_i.spot_radius != '0);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (scored) begin
            state_d = ST_PREP;
          end else if (in_data_i.frame_last) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_PREP:   state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_DIV;
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_SCORE;
        end
      end
      ST_SCORE:  state_d = item_q.frame_last ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_LAUNCH: div_start   = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- circularity divider ----------------
  bscs_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .sts_o   (div_sts),
    .quo_o   (quo)
  );

  // ---------------- operand prep ----------------
  // city-block distance counts only when a previous cursor exists
  always_comb begin
    dist_d = '0;
    if (item_q.prev_radius != '0) begin
      dist_d = DistW'(abs_diff(item_q.spot_x, item_q.prev_x))
             + DistW'(abs_diff(item_q.spot_y, item_q.prev_y));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_PREP) begin
      rr_q   <= item_q.spot_radius * item_q.spot_radius;
      // 200 * area, then times 65536
      num_q  <= {SqW'(item_q.spot_area * CircMult), 16'h0000};
      rad_q  <= abs_diff(item_q.spot_radius, target_q);
      dist_q <= dist_d;
    end
    if (state_q == ST_SCALE) begin
      den_q <= rr_q * PiQ16;
    end
  end

  // ---------------- score and running minimum ----------------
  // 100 - ratio + radius term + distance term, fits 24 bits signed
  assign score = CircBase
               - $signed({2'b00, quo})
               + $signed({{(ScoreW + 1 - CoordW){1'b0}}, rad_q})
               + $signed({{(ScoreW + 1 - DistW){1'b0}}, dist_q});

  // strict compare keeps the first of equal scores
  assign take = (state_q == ST_SCORE) && (score < $signed({best_score_q[ScoreW-1], best_score_q}));
  assign emit = (state_d == ST_OUT) && (state_q != ST_OUT);

  always_comb begin
    held_nx      = held_q;
    best_score_d = best_score_q;
    if (take) begin
      held_nx.best_x      = item_q.spot_x;
      held_nx.best_y      = item_q.spot_y;
      held_nx.best_radius = item_q.spot_radius;
      held_nx.best_area   = item_q.spot_area;
      best_score_d        = score[ScoreW-1:0];
    end
    held_d = held_nx;
    out_d  = out_q;
    // frame end: publish the held blob and start the next frame clean
    if (emit) begin
      out_d        = held_nx;
      held_d       = '0;
      best_score_d = ScoreBound;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      best_score_q <= ScoreBound;
      held_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
      best_score_q <= best_score_d;
      held_q       <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  // input and output sides never open together
  `BSCS_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // the divider finishes only while the sequencer waits on it
  `BSCS_ASSERT_IMPL(a_div_done, clk_i, rst_ni, div_sts.done, state_q == ST_DIV)
  // a taken result leaves a freshly cleared frame
  `BSCS_ASSERT_NEXT(a_frame_clear, clk_i, rst_ni, out_valid_o && out_ready_i, best_score_q == ScoreBound)
  // a held blob exists exactly when the running minimum left the bound
  `BSCS_ASSERT_IMPL(a_held_match, clk_i, rst_ni, 1'b1, (held_q.best_radius != '0) == (best_score_q != ScoreBound))

endmodule

/* rtl/core/bscs_divider.sv */
// ----------------------------------------------------------------------------
// bscs_divider
// serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bscs_divider
  import bscs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output bscs_div_sts_t       sts_o,
  output logic [QuoW-1:0]     quo_o
);

  logic             busy_q;
  logic [StepW-1:0] cnt_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW-1:0]  rem_d;
  logic [QuoW-1:0]  nsh_q;
  logic [DenW-1:0]  den_q;
  logic [QuoW-1:0]  quo_q;
  logic [DenW:0]    shifted;
  logic [DenW+1:0]  diff;
  logic             qbit;

  // top numerator bits are already below the divisor, so only QuoW steps
  assign shifted = {rem_q, nsh_q[QuoW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign qbit    = ~diff[DenW+1];
  assign rem_d   = qbit ? diff[DenW-1:0] : shifted[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= StepW'(QuoW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DenW'(num_i[NumW-1:QuoW]);
      nsh_q <= num_i[QuoW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      nsh_q <= {nsh_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], qbit};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == '0);
  assign quo_o      = quo_q;

endmodule
